### rtl/tht_pkg.sv
// Shared types and constants for the TEC heater thermostat.
// Holds the item structs, mode and command codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package tht_pkg;

    localparam int COOLER_CHANNELS = 4;
    localparam int HEATER_CHANNELS = 4;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Saturation limits of the drive outputs.
    localparam logic [11:0] COOLER_MV_MAX = 12'd3000;
    localparam logic [6:0]  HEATER_PCT_MAX = 7'd100;

    // Reset values of the configuration registers.
    localparam logic [7:0] WAIT_LIMIT_RST = 8'd30;
    localparam logic [9:0] HYSTERESIS_RST = 10'd10;

    typedef enum logic [2:0] {
        MODE_MANUAL    = 3'd0,
        MODE_COOL      = 3'd1,
        MODE_WAIT_WARM = 3'd2,
        MODE_HEAT      = 3'd3,
        MODE_WAIT_COOL = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_AUTO   = 2'd1,
        CMD_MANUAL = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT    = 3'd0,
        CFG_COOLER_MASK = 3'd1,
        CFG_HEATER_MASK = 3'd2,
        CFG_HEATER_DUTY = 3'd3,
        CFG_COOLER_MV   = 3'd4,
        CFG_WAIT_LIMIT  = 3'd5,
        CFG_HYSTERESIS  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] temperature;
    } t_tht_in;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  cooler_enable;
        logic [11:0] cooler_drive_mv;
        logic [3:0]  heater_enable;
        logic [6:0]  heater_drive_pct;
    } t_tht_out;

    // Channel mask limited to the channels that exist, within the 4-bit field.
    function automatic logic [3:0] chan_mask(input int n);
        logic [3:0] m;
        m = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < n) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

### rtl/tec_heater_thermostat.sv
// Top level of the TEC heater thermostat: mode state machine, configuration
// registers and the registered result stage.
// Depends on tht_pkg.
`timescale 1ns / 1ps

// Five-mode bang-bang thermostat with hysteresis. Each input item (a tick or a
// start-auto / return-to-manual command, plus a temperature reading) produces
// exactly one result item showing the mode after the step and the cooler and
// heater drive values for that mode. The transition
// logic runs between the input handshake and the result register, and a new
// item is accepted in every cycle as long as the result register is empty or
// is being emptied in the same cycle. Configuration registers are written
// through a plain write port and are read at the moment an item is accepted.
module tec_heater_thermostat #(
    parameter int COOLER_CHANNELS = tht_pkg::COOLER_CHANNELS,
    parameter int HEATER_CHANNELS = tht_pkg::HEATER_CHANNELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  tht_pkg::t_tht_in                     i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output tht_pkg::t_tht_out                    o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [tht_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tht_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam logic [3:0] COOLER_CHAN_MASK = tht_pkg::chan_mask(COOLER_CHANNELS);
    localparam logic [3:0] HEATER_CHAN_MASK = tht_pkg::chan_mask(HEATER_CHANNELS);

    // Configuration registers.
    logic signed [15:0] r_setpoint;
    logic [3:0]         r_cooler_mask;
    logic [3:0]         r_heater_mask;
    logic [6:0]         r_heater_duty;
    logic [11:0]        r_cooler_mv;
    logic [7:0]         r_wait_limit;
    logic [9:0]         r_hysteresis;

    // Thermostat state.
    tht_pkg::t_mode     r_mode, n_mode;
    logic [7:0]         r_wait_count, n_wait_count;

    // Result stage.
    logic               r_out_valid;
    tht_pkg::t_tht_out  r_out_data, n_out_data;

    logic               accept;
    tht_pkg::t_cmd      cmd;
    logic signed [15:0] temp;
    logic               above;
    logic               below;
    logic signed [17:0] deficit;
    logic               deficit_big;
    logic [7:0]         count_inc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign cmd   = tht_pkg::t_cmd'(i_in_data.cmd);
    assign temp  = i_in_data.temperature;
    assign above = temp > r_setpoint;
    assign below = temp < r_setpoint;
    assign deficit     = 18'(r_setpoint) - 18'(temp);
    assign deficit_big = deficit > $signed({8'd0, r_hysteresis});
    assign count_inc   = (r_wait_count == 8'hFF) ? r_wait_count : r_wait_count + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint    <= '0;
            r_cooler_mask <= '0;
            r_heater_mask <= '0;
            r_heater_duty <= '0;
            r_cooler_mv   <= '0;
            r_wait_limit  <= tht_pkg::WAIT_LIMIT_RST;
            r_hysteresis  <= tht_pkg::HYSTERESIS_RST;
        end else if (i_cfg_we) begin
            case (tht_pkg::t_cfg_idx'(i_cfg_idx))
                tht_pkg::CFG_SETPOINT:    r_setpoint    <= i_cfg_data;
                tht_pkg::CFG_COOLER_MASK: r_cooler_mask <= i_cfg_data[3:0];
                tht_pkg::CFG_HEATER_MASK: r_heater_mask <= i_cfg_data[3:0];
                tht_pkg::CFG_HEATER_DUTY: r_heater_duty <= i_cfg_data[6:0];
                tht_pkg::CFG_COOLER_MV:   r_cooler_mv   <= i_cfg_data[11:0];
                tht_pkg::CFG_WAIT_LIMIT:  r_wait_limit  <= i_cfg_data[7:0];
                tht_pkg::CFG_HYSTERESIS:  r_hysteresis  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Next mode and wait count for the item at the input.
    always_comb begin
        n_mode       = r_mode;
        n_wait_count = r_wait_count;
        if (r_mode == tht_pkg::MODE_MANUAL) begin
            if (cmd == tht_pkg::CMD_AUTO) begin
                n_mode       = above ? tht_pkg::MODE_COOL : tht_pkg::MODE_WAIT_WARM;
                n_wait_count = '0;
            end
        end else if (cmd == tht_pkg::CMD_MANUAL) begin
            // The wait count is kept on the way back to manual.
            n_mode = tht_pkg::MODE_MANUAL;
        end else if (cmd == tht_pkg::CMD_TICK) begin
            case (r_mode)
                tht_pkg::MODE_COOL: begin
                    if (!above) begin
                        n_mode       = tht_pkg::MODE_WAIT_WARM;
                        n_wait_count = '0;
                    end
                end
                tht_pkg::MODE_WAIT_WARM: begin
                    if (above) begin
                        n_mode       = tht_pkg::MODE_COOL;
                        n_wait_count = '0;
                    end else if (count_inc >= r_wait_limit || deficit_big) begin
                        n_mode       = tht_pkg::MODE_HEAT;
                        n_wait_count = '0;
                    end else begin
                        n_wait_count = count_inc;
                    end
                end
                tht_pkg::MODE_HEAT: begin
                    // Entering wait-for-cooling keeps the count running.
                    if (!below) begin
                        n_mode = tht_pkg::MODE_WAIT_COOL;
                    end
                end
                tht_pkg::MODE_WAIT_COOL: begin
                    if (below) begin
                        n_mode       = tht_pkg::MODE_HEAT;
                        n_wait_count = '0;
                    end else if (count_inc >= r_wait_limit) begin
                        n_mode       = tht_pkg::MODE_COOL;
                        n_wait_count = '0;
                    end else begin
                        n_wait_count = count_inc;
                    end
                end
                default: begin
                    n_mode = tht_pkg::MODE_MANUAL;
                end
            endcase
        end
    end

    // Drive values for the mode after the step.
    always_comb begin
        n_out_data                  = '0;
        n_out_data.mode             = n_mode;
        if (n_mode == tht_pkg::MODE_COOL) begin
            n_out_data.cooler_enable   = r_cooler_mask & COOLER_CHAN_MASK;
            n_out_data.cooler_drive_mv = (r_cooler_mv > tht_pkg::COOLER_MV_MAX)
                                       ? tht_pkg::COOLER_MV_MAX : r_cooler_mv;
        end else if (n_mode == tht_pkg::MODE_HEAT) begin
            n_out_data.heater_enable    = r_heater_mask & HEATER_CHAN_MASK;
            n_out_data.heater_drive_pct = (r_heater_duty > tht_pkg::HEATER_PCT_MAX)
                                        ? tht_pkg::HEATER_PCT_MAX : r_heater_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= tht_pkg::MODE_MANUAL;
            r_wait_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_mode       <= n_mode;
                r_wait_count <= n_wait_count;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
